// ----- rtl/core/vdi_pkg.sv -----
// Shared types and constants for the vertex dedup indexer.
`timescale 1ns / 1ps

package vdi_pkg;

  localparam int unsigned FIELD_W = 16;   // width of each corner index port
  localparam int unsigned VIDX_W  = 10;   // emitted vertex index width
  localparam int unsigned TOTAL_W = 24;   // index counter width (wraps)
  localparam int unsigned MUL_W   = 32;   // shared multiplier operand width

  // Golden-ratio multiplier used to scatter keys over the table.
  localparam logic [MUL_W-1:0] HASH_MULT = 32'h9E37_79B1;

  // Upper half of the mixed hash feeds the range reduction.
  localparam int unsigned MIX_W = 16;

  typedef enum logic [2:0] {
    ST_CLEAR,   // post-reset sweep writing empty entries
    ST_IDLE,    // waiting for start
    ST_HASH,    // key times golden constant
    ST_RANGE,   // mixed hash scaled into [0, TABLE_DEPTH)
    ST_PROBE,   // first table read
    ST_CHECK    // compare, then insert, finish or probe next slot
  } vdi_state_e;

endpackage

// ----- rtl/core/vertex_dedup_indexer_top.sv -----
// Vertex deduplication indexer: hashed triple table with sequential index assignment.
`timescale 1ns / 1ps

// Channel  | Ports                                              | Handshake
// ---------+----------------------------------------------------+------------------------------
// item in  | position_index_i texcoord_index_i normal_index_i   | taken at edge with start &&
//          | object_end_i                                       | !busy
// result   | vertex_index_o is_new_o table_full_o object_done_o | result_valid_o high for one
//          | object_count_o object_offset_o                     | cycle, always taken
//
// Sequence: after an accept the item passes through HASH, RANGE and PROBE, then CHECK for
//   each table slot probed, before the return to IDLE. The result strobe coincides with
//   the next possible accept. Probes are serialized on the single table read port.
// A miss against a full table probes every slot.
// Reset: after rst_ni releases, a clearing pass writes every table slot empty, one slot per
//   cycle; busy is high during the pass.
// Stalls: none on the result side; busy alone holds off new items.
module vertex_dedup_indexer_top #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned INDEX_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [vdi_pkg::FIELD_W-1:0] position_index_i,
  input  logic [vdi_pkg::FIELD_W-1:0] texcoord_index_i,
  input  logic [vdi_pkg::FIELD_W-1:0] normal_index_i,
  input  logic                        object_end_i,
  output logic                        result_valid_o,
  output logic [vdi_pkg::VIDX_W-1:0]  vertex_index_o,
  output logic                        is_new_o,
  output logic                        table_full_o,
  output logic                        object_done_o,
  output logic [vdi_pkg::TOTAL_W-1:0] object_count_o,
  output logic [vdi_pkg::TOTAL_W-1:0] object_offset_o
);

  // Each index keeps at most its low INDEX_BITS bits; ports are 16 bits wide.
  localparam int unsigned KEY_BITS = (INDEX_BITS < vdi_pkg::FIELD_W) ? INDEX_BITS
                                                                     : vdi_pkg::FIELD_W;
  localparam int unsigned KEY_W    = 3 * KEY_BITS;
  localparam int unsigned ADDR_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PAD_W    = 2 * vdi_pkg::MUL_W;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  typedef struct packed {
    logic                       valid;
    logic [KEY_W-1:0]           key;
    logic [vdi_pkg::VIDX_W-1:0] vidx;
  } entry_t;

  // ---------------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------------
  vdi_pkg::vdi_state_e state_q, state_d;

  logic [KEY_W-1:0]            key_q, key_d;
  logic                        end_q, end_d;
  logic [PAD_W-1:0]            mul_q, mul_d;
  logic [ADDR_W-1:0]           addr_q, addr_d;
  logic [CNT_W-1:0]            probes_q, probes_d;
  logic [CNT_W-1:0]            next_vertex_q, next_vertex_d;
  logic [vdi_pkg::TOTAL_W-1:0] emitted_q, emitted_d;
  logic [vdi_pkg::TOTAL_W-1:0] obj_start_q, obj_start_d;

  logic                        rvalid_q, rvalid_d;
  logic [vdi_pkg::VIDX_W-1:0]  vidx_q, vidx_d;
  logic                        new_q, new_d;
  logic                        full_q, full_d;
  logic                        done_q, done_d;
  logic [vdi_pkg::TOTAL_W-1:0] count_q, count_d;
  logic [vdi_pkg::TOTAL_W-1:0] offset_q, offset_d;

  // ---------------------------------------------------------------------------------
  // Table memory: one port, registered read
  // ---------------------------------------------------------------------------------
  entry_t             mem [TABLE_DEPTH];
  entry_t             rd_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  entry_t             mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_q <= mem[mem_addr];
  end

  // ---------------------------------------------------------------------------------
  // Shared multiplier: hash mixing, then range reduction into the table
  // ---------------------------------------------------------------------------------
  logic [vdi_pkg::MUL_W-1:0] mul_a, mul_b;
  logic [PAD_W-1:0]          key_pad;
  logic [vdi_pkg::MUL_W-1:0] key_fold;

  assign key_pad  = {{(PAD_W - KEY_W){1'b0}}, key_q};
  assign key_fold = key_pad[vdi_pkg::MUL_W-1:0] ^ key_pad[PAD_W-1:vdi_pkg::MUL_W];

  // Vertex index of the next insert, zero-extended or truncated to 10 bits.
  logic [CNT_W+vdi_pkg::VIDX_W-1:0] nv_ext;
  assign nv_ext = {{vdi_pkg::VIDX_W{1'b0}}, next_vertex_q};

  logic                        hit, empty, full, exhausted, finish, emit;
  logic [vdi_pkg::TOTAL_W-1:0] total_next;
  logic [ADDR_W-1:0]           addr_inc;

  assign hit       = rd_q.valid && (rd_q.key == key_q);
  assign empty     = !rd_q.valid;
  assign full      = (next_vertex_q == DEPTH_CNT);
  assign exhausted = (probes_q == DEPTH_CNT);
  assign addr_inc  = (addr_q == LAST_ADDR) ? '0 : addr_q + 1'b1;

  // ---------------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------------
  always_comb begin
    state_d       = state_q;
    key_d         = key_q;
    end_d         = end_q;
    mul_d         = mul_q;
    addr_d        = addr_q;
    probes_d      = probes_q;
    next_vertex_d = next_vertex_q;
    emitted_d     = emitted_q;
    obj_start_d   = obj_start_q;
    rvalid_d      = 1'b0;
    vidx_d        = vidx_q;
    new_d         = new_q;
    full_d        = full_q;
    done_d        = done_q;
    count_d       = count_q;
    offset_d      = offset_q;
    mem_we        = 1'b0;
    mem_addr      = addr_q;
    mem_wdata     = '0;
    mul_a         = key_fold;
    mul_b         = vdi_pkg::HASH_MULT;
    finish        = 1'b0;
    emit          = 1'b0;
    total_next    = emitted_q;

    case (state_q)
      vdi_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        addr_d = addr_inc;
        if (addr_q == LAST_ADDR) begin
          state_d = vdi_pkg::ST_IDLE;
        end
      end
      vdi_pkg::ST_IDLE: begin
        if (start) begin
          key_d   = {normal_index_i[KEY_BITS-1:0], texcoord_index_i[KEY_BITS-1:0],
                     position_index_i[KEY_BITS-1:0]};
          end_d   = object_end_i;
          state_d = vdi_pkg::ST_HASH;
        end
      end
      vdi_pkg::ST_HASH: begin
        mul_d   = PAD_W'(mul_a * mul_b);
        state_d = vdi_pkg::ST_RANGE;
      end
      vdi_pkg::ST_RANGE: begin
        // Scale the top of the mixed word by the depth: slot lands below TABLE_DEPTH.
        mul_a   = {{(vdi_pkg::MUL_W - vdi_pkg::MIX_W){1'b0}},
                   mul_q[vdi_pkg::MUL_W-1 -: vdi_pkg::MIX_W]};
        mul_b   = vdi_pkg::MUL_W'(TABLE_DEPTH);
        mul_d   = PAD_W'(mul_a * mul_b);
        state_d = vdi_pkg::ST_PROBE;
      end
      vdi_pkg::ST_PROBE: begin
        mem_addr = mul_q[vdi_pkg::MIX_W +: ADDR_W];
        addr_d   = mul_q[vdi_pkg::MIX_W +: ADDR_W];
        probes_d = CNT_W'(1);
        state_d  = vdi_pkg::ST_CHECK;
      end
      vdi_pkg::ST_CHECK: begin
        if (hit) begin
          finish = 1'b1;
          emit   = 1'b1;
          vidx_d = rd_q.vidx;
          new_d  = 1'b0;
          full_d = 1'b0;
        end else if ((empty && !full) || exhausted) begin
          finish = 1'b1;
          if (!full) begin
            // Linear probing stops on the first empty slot: store the triple there.
            mem_we        = 1'b1;
            mem_wdata     = '{valid: 1'b1, key: key_q, vidx: nv_ext[vdi_pkg::VIDX_W-1:0]};
            next_vertex_d = next_vertex_q + 1'b1;
            emit          = 1'b1;
            vidx_d        = nv_ext[vdi_pkg::VIDX_W-1:0];
            new_d         = 1'b1;
            full_d        = 1'b0;
          end else begin
            vidx_d = '0;
            new_d  = 1'b0;
            full_d = 1'b1;
          end
        end else begin
          mem_addr = addr_inc;
          addr_d   = addr_inc;
          probes_d = probes_q + 1'b1;
        end

        if (finish) begin
          total_next = emitted_q + vdi_pkg::TOTAL_W'(emit);
          emitted_d  = total_next;
          rvalid_d   = 1'b1;
          done_d     = end_q;
          if (end_q) begin
            count_d     = total_next - obj_start_q;
            offset_d    = obj_start_q;
            obj_start_d = total_next;
          end else begin
            count_d  = '0;
            offset_d = '0;
          end
          state_d = vdi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vdi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= vdi_pkg::ST_CLEAR;
      addr_q        <= '0;
      probes_q      <= '0;
      next_vertex_q <= '0;
      emitted_q     <= '0;
      obj_start_q   <= '0;
      rvalid_q      <= 1'b0;
    end else begin
      state_q       <= state_d;
      addr_q        <= addr_d;
      probes_q      <= probes_d;
      next_vertex_q <= next_vertex_d;
      emitted_q     <= emitted_d;
      obj_start_q   <= obj_start_d;
      rvalid_q      <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    end_q    <= end_d;
    mul_q    <= mul_d;
    vidx_q   <= vidx_d;
    new_q    <= new_d;
    full_q   <= full_d;
    done_q   <= done_d;
    count_q  <= count_d;
    offset_q <= offset_d;
  end

  assign busy            = (state_q != vdi_pkg::ST_IDLE);
  assign result_valid_o  = rvalid_q;
  assign vertex_index_o  = vidx_q;
  assign is_new_o        = new_q;
  assign table_full_o    = full_q;
  assign object_done_o   = done_q;
  assign object_count_o  = count_q;
  assign object_offset_o = offset_q;

  // ---------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while sequencer still busy");

  a_new_xor_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(is_new_o && table_full_o))
    else $error("item flagged both new and table full");

  a_full_zero_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && table_full_o) |-> (vertex_index_o == '0))
    else $error("table full result carries nonzero index");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_vertex_q <= DEPTH_CNT)
    else $error("stored triple count beyond table depth");

endmodule

// ----- tb/vdi_checker.sv -----
// Checker for the vertex dedup indexer: watches both channels, predicts and compares results.
`timescale 1ns / 1ps

module vdi_checker #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned INDEX_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  logic [vdi_pkg::FIELD_W-1:0] position_index_i,
  input  logic [vdi_pkg::FIELD_W-1:0] texcoord_index_i,
  input  logic [vdi_pkg::FIELD_W-1:0] normal_index_i,
  input  logic                        object_end_i,
  input  logic                        result_valid_i,
  input  logic [vdi_pkg::VIDX_W-1:0]  vertex_index_i,
  input  logic                        is_new_i,
  input  logic                        table_full_i,
  input  logic                        object_done_i,
  input  logic [vdi_pkg::TOTAL_W-1:0] object_count_i,
  input  logic [vdi_pkg::TOTAL_W-1:0] object_offset_i,
  output int unsigned                 mismatch_count_o,
  output int unsigned                 outstanding_o
);

  typedef struct packed {
    logic [vdi_pkg::VIDX_W-1:0]  vertex_index;
    logic                        is_new;
    logic                        table_full;
    logic                        object_done;
    logic [vdi_pkg::TOTAL_W-1:0] object_count;
    logic [vdi_pkg::TOTAL_W-1:0] object_offset;
  } corner_result_t;

  // Shadow of the vertex table: masked key -> assigned vertex index.
  logic [vdi_pkg::VIDX_W-1:0]  vertex_of_key [bit [3*vdi_pkg::FIELD_W-1:0]];
  int unsigned                 stored_triples = 0;
  logic [vdi_pkg::TOTAL_W-1:0] emitted_total  = '0;
  logic [vdi_pkg::TOTAL_W-1:0] object_start   = '0;

  corner_result_t expected_results [$];
  corner_result_t want;
  int unsigned    errors = 0;

  assign mismatch_count_o = errors;

  function automatic corner_result_t predict_corner(
      input logic [vdi_pkg::FIELD_W-1:0] pos,
      input logic [vdi_pkg::FIELD_W-1:0] tex,
      input logic [vdi_pkg::FIELD_W-1:0] nrm,
      input logic                        last);
    corner_result_t                r;
    logic [vdi_pkg::FIELD_W-1:0]   m;
    bit [3*vdi_pkg::FIELD_W-1:0]   key;
    m   = (INDEX_BITS >= vdi_pkg::FIELD_W) ? '1
                                           : vdi_pkg::FIELD_W'((32'd1 << INDEX_BITS) - 1);
    key = {nrm & m, tex & m, pos & m};
    r   = '0;
    if (vertex_of_key.exists(key)) begin
      r.vertex_index = vertex_of_key[key];
    end else if (stored_triples < TABLE_DEPTH) begin
      vertex_of_key[key] = stored_triples[vdi_pkg::VIDX_W-1:0];
      r.vertex_index     = stored_triples[vdi_pkg::VIDX_W-1:0];
      r.is_new           = 1'b1;
      stored_triples++;
    end else begin
      r.table_full = 1'b1;
    end
    if (!r.table_full) emitted_total = emitted_total + 1'b1;
    r.object_done = last;
    if (last) begin
      r.object_count  = emitted_total - object_start;
      r.object_offset = object_start;
      object_start    = emitted_total;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result side first, so an accept on the same edge never pairs with its own result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_of_key.delete();
      stored_triples = 0;
      emitted_total  = '0;
      object_start   = '0;
      expected_results.delete();
      outstanding_o <= 0;
    end else begin
      if (result_valid_i === 1'b1) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no item waiting, expected none, actual vertex %0h",
                   $time, vertex_index_i);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("vertex_index",  32'(want.vertex_index),  32'(vertex_index_i));
          check_field("is_new",        32'(want.is_new),        32'(is_new_i));
          check_field("table_full",    32'(want.table_full),    32'(table_full_i));
          check_field("object_done",   32'(want.object_done),   32'(object_done_i));
          check_field("object_count",  32'(want.object_count),  32'(object_count_i));
          check_field("object_offset", 32'(want.object_offset), 32'(object_offset_i));
        end
      end
      if (start && !busy) begin
        expected_results.insert(expected_results.size(),
                                predict_corner(position_index_i, texcoord_index_i,
                                               normal_index_i, object_end_i));
      end
      outstanding_o <= expected_results.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Testbench top: corner stimulus for the vertex dedup indexer, checker hookup and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TABLE_DEPTH  = 1024;
  localparam int unsigned INDEX_BITS   = 16;
  localparam int unsigned RANDOM_ITEMS = 1830;
  // Worst case is a full-table miss: every slot probed.
  localparam int unsigned CYCLE_LIMIT  = 10_000_000;
  // Tail after the last result: long enough for a full-table probe to show a stray strobe.
  localparam int unsigned DRAIN_CYCLES = TABLE_DEPTH + 16;

  logic                        clk_i;
  logic                        rst_ni         = 1'b0;
  logic                        start          = 1'b0;
  logic                        busy;
  logic [vdi_pkg::FIELD_W-1:0] position_index = '0;
  logic [vdi_pkg::FIELD_W-1:0] texcoord_index = '0;
  logic [vdi_pkg::FIELD_W-1:0] normal_index   = '0;
  logic                        object_end     = 1'b0;

  logic                        result_valid;
  logic [vdi_pkg::VIDX_W-1:0]  vertex_index;
  logic                        is_new;
  logic                        table_full;
  logic                        object_done;
  logic [vdi_pkg::TOTAL_W-1:0] object_count;
  logic [vdi_pkg::TOTAL_W-1:0] object_offset;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned cycle_count = 0;

  // Triples sent so far, used to steer repeats and to know when the table is full.
  bit                            triple_seen [bit [3*vdi_pkg::FIELD_W-1:0]];
  logic [3*vdi_pkg::FIELD_W-1:0] triple_pool [$];

  vertex_dedup_indexer_top #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .position_index_i(position_index),
    .texcoord_index_i(texcoord_index),
    .normal_index_i  (normal_index),
    .object_end_i    (object_end),
    .result_valid_o  (result_valid),
    .vertex_index_o  (vertex_index),
    .is_new_o        (is_new),
    .table_full_o    (table_full),
    .object_done_o   (object_done),
    .object_count_o  (object_count),
    .object_offset_o (object_offset)
  );

  vdi_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) result_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .position_index_i(position_index),
    .texcoord_index_i(texcoord_index),
    .normal_index_i  (normal_index),
    .object_end_i    (object_end),
    .result_valid_i  (result_valid),
    .vertex_index_i  (vertex_index),
    .is_new_i        (is_new),
    .table_full_i    (table_full),
    .object_done_i   (object_done),
    .object_count_i  (object_count),
    .object_offset_i (object_offset),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: the run must end well inside the cycle budget.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL vertex_dedup_indexer_top");
    $finish;
  end

  // Present one item and hold it until the block takes it (start high, busy low).
  // Leaves start high, so back-to-back items never drop it in between.
  task automatic send_corner(input logic [vdi_pkg::FIELD_W-1:0] pos,
                             input logic [vdi_pkg::FIELD_W-1:0] tex,
                             input logic [vdi_pkg::FIELD_W-1:0] nrm, input logic last);
    bit [3*vdi_pkg::FIELD_W-1:0] key;
    key = {nrm, tex, pos};
    position_index <= pos;
    texcoord_index <= tex;
    normal_index   <= nrm;
    object_end     <= last;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (!triple_seen.exists(key)) begin
      triple_seen[key] = 1'b1;
      triple_pool.insert(triple_pool.size(), key);
    end
  endtask

  // Sender gap: start low, junk on the item ports so nothing leaks in while idle.
  task automatic idle_for(input int unsigned cycles);
    if (cycles != 0) begin
      start          <= 1'b0;
      position_index <= vdi_pkg::FIELD_W'($urandom());
      texcoord_index <= vdi_pkg::FIELD_W'($urandom());
      normal_index   <= vdi_pkg::FIELD_W'($urandom());
      object_end     <= 1'($urandom_range(0, 1));
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Mostly new triples until the table fills, then mostly repeats with a trickle of
  // misses that must come back flagged full. Near-repeats differ from a stored triple
  // in a single bit, which stresses the key compare along a probe chain.
  task automatic send_random_corner();
    logic [3*vdi_pkg::FIELD_W-1:0] key;
    int unsigned                   roll;
    int unsigned                   new_pct;
    int unsigned                   pick;
    new_pct = (triple_seen.num() < TABLE_DEPTH) ? 62 : 10;
    roll    = $urandom_range(0, 99);
    if (triple_pool.size() == 0 || roll < new_pct) begin
      key = {vdi_pkg::FIELD_W'($urandom()), vdi_pkg::FIELD_W'($urandom()),
             vdi_pkg::FIELD_W'($urandom())};
      if ($urandom_range(0, 9) == 0) begin
        pick = $urandom_range(0, 2);
        key[pick*vdi_pkg::FIELD_W +: vdi_pkg::FIELD_W] = ($urandom_range(0, 1) != 0) ? '1
                                                                                     : '0;
      end
    end else begin
      key = triple_pool[$urandom_range(0, triple_pool.size() - 1)];
      if (roll < new_pct + 10) begin
        pick = $urandom_range(0, 3*vdi_pkg::FIELD_W - 1);
        key[pick] = ~key[pick];
      end
    end
    send_corner(key[vdi_pkg::FIELD_W-1:0], key[2*vdi_pkg::FIELD_W-1:vdi_pkg::FIELD_W],
                key[3*vdi_pkg::FIELD_W-1:2*vdi_pkg::FIELD_W],
                1'($urandom_range(0, 7) == 0));
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The clearing pass after reset keeps busy high; send_corner just waits it out.

    // ---- directed corners ----
    // first triple gets index 0, a repeat hits it; object of two corners
    send_corner(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_corner(16'h0000, 16'h0000, 16'h0000, 1'b1);
    // all-ones triple, then one field at max with the rest zero
    send_corner(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    idle_for(3);
    send_corner(16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    send_corner(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    send_corner(16'h0000, 16'h0000, 16'hFFFF, 1'b1);
    // two single-corner objects with an idle gap between them, both hits
    send_corner(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    idle_for(7);
    send_corner(16'h0000, 16'h0000, 16'h0000, 1'b1);
    // keys one bit away from stored ones must be new
    send_corner(16'h0001, 16'h0000, 16'h0000, 1'b0);
    send_corner(16'h0000, 16'h0000, 16'h8000, 1'b0);
    send_corner(16'h0000, 16'h8000, 16'h0000, 1'b0);
    send_corner(16'hFFFE, 16'hFFFF, 16'hFFFF, 1'b0);
    // alternating patterns and their fields swapped
    send_corner(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
    idle_for(1);
    send_corner(16'h5555, 16'hAAAA, 16'h5555, 1'b1);
    send_corner(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
    send_corner(16'h5555, 16'hAAAA, 16'h5555, 1'b0);
    send_corner(16'h1234, 16'h5678, 16'h9ABC, 1'b0);
    send_corner(16'h0001, 16'h0000, 16'h0000, 1'b1);
    // Table full is reached in the random part once TABLE_DEPTH distinct triples are in.
    // The 24-bit counter wrap needs 2^24 items and is out of reach here.

    // ---- random bursts ----
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && sent < RANDOM_ITEMS) begin
        send_random_corner();
        burst--;
        sent++;
      end
      // about a quarter of bursts run straight into the next one
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      idle_for(gap);
    end

    // ---- drain ----
    start <= 1'b0;
    // one edge so the checker's count includes the last accepted item
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASS vertex_dedup_indexer_top");
    end else begin
      $display("FAIL vertex_dedup_indexer_top");
    end
    $finish;
  end

endmodule

// ----- vertex_dedup_indexer_top.f -----
rtl/core/vdi_pkg.sv
rtl/core/vertex_dedup_indexer_top.sv
tb/vdi_checker.sv
tb/testbench.sv
